### hdl/gaussian_noise_box_muller_top_assert.svh
// Assertion macros shared by the checker of the Gaussian noise generator.
`ifndef GAUSSIAN_NOISE_BOX_MULLER_TOP_ASSERT_SVH
`define GAUSSIAN_NOISE_BOX_MULLER_TOP_ASSERT_SVH

// Implication that is abandoned whenever reset is applied during the attempt.
`define GNBM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define GNBM_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/gnbm_pkg.sv
// Types, constants and register codes of the Box-Muller Gaussian noise generator.
package gnbm_pkg;

    localparam int GNBM_UNIFORM_BITS = 32;
    localparam int GNBM_CFG_IDX_W    = 8;

    localparam logic [GNBM_CFG_IDX_W-1:0] GNBM_CFG_NOISE_MEAN   = 8'd0;
    localparam logic [GNBM_CFG_IDX_W-1:0] GNBM_CFG_NOISE_SPREAD = 8'd1;

    localparam logic [15:0] GNBM_MEAN_RESET   = 16'd0;
    localparam logic [15:0] GNBM_SPREAD_RESET = 16'd256;

    localparam logic [30:0] GNBM_Q30_ONE     = 31'h4000_0000;
    localparam logic [31:0] GNBM_TWO_LN2_Q30 = 32'd1488522236;
    localparam logic [31:0] GNBM_HALF_PI_Q30 = 32'd1686629713;
    localparam logic [29:0] GNBM_OCT_SPAN    = 30'h2000_0000;

    localparam int GNBM_LOG_CELLS    = 24;
    localparam int GNBM_SQRT_CELLS   = 21;
    localparam int GNBM_SQRT_TOP     = 40;
    localparam int GNBM_HORNER_CELLS = 4;

    localparam int GNBM_DIV_SIN [GNBM_HORNER_CELLS] = '{72, 42, 20, 6};
    localparam int GNBM_DIV_COS [GNBM_HORNER_CELLS] = '{90, 56, 30, 12};

    // Cycles from the accepting edge to the edge at which the result is taken.
    localparam int GNBM_LATENCY = 51;

    typedef struct packed {
        logic [31:0] u_radius;
        logic [31:0] u_angle;
    } t_gnbm_item;

    typedef struct packed {
        logic signed [31:0] noise_a;
        logic signed [31:0] noise_b;
    } t_gnbm_result;

endpackage

### hdl/gaussian_noise_box_muller_top.sv
// Box-Muller Gaussian noise generator: log, square root and trig cell chains.
// The strobe rises together with the registered result.
// Throughput: one uniform pair per cycle; busy stays low, the pipeline never stalls.
// A pair whose masked radius word is zero moves through but gives no strobe.
// Reset (synchronous, active low) empties the pipeline and sets mean 0, spread 1.0.
module gaussian_noise_box_muller_top
    import gnbm_pkg::*;
#(
    parameter int UNIFORM_BITS = GNBM_UNIFORM_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  t_gnbm_item                i_item,
    output logic                      busy,
    output logic                      o_strobe,
    output t_gnbm_result              o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [GNBM_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]               i_cfg_data
);

    localparam logic [31:0] UMASK = 32'hFFFF_FFFF << (32 - UNIFORM_BITS);
    localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
    localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

    function automatic logic signed [31:0] gnbm_sample(
        input logic signed [15:0] mean,
        input logic [27:0]        mag,
        input logic               neg
    );
        logic signed [33:0] base;
        logic signed [33:0] mag_s;
        logic signed [33:0] sum;
        base  = $signed({{10{mean[15]}}, mean, 8'd0});
        mag_s = $signed({6'd0, mag});
        sum   = neg ? base - mag_s : base + mag_s;
        if (sum > SAT_MAX) begin
            return SAT_MAX[31:0];
        end else if (sum < SAT_MIN) begin
            return SAT_MIN[31:0];
        end
        return sum[31:0];
    endfunction

    // Configuration registers
    logic signed [15:0] r_noise_mean;
    logic [15:0]        r_noise_spread;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_mean   <= GNBM_MEAN_RESET;
            r_noise_spread <= GNBM_SPREAD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                GNBM_CFG_NOISE_MEAN:   r_noise_mean   <= i_cfg_data;
                GNBM_CFG_NOISE_SPREAD: r_noise_spread <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    logic        accept;
    logic        r_in_valid;
    logic [31:0] r_ur;
    logic [31:0] r_ua;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept && ((i_item.u_radius & UMASK) != 32'd0);
        end
        r_ur <= i_item.u_radius & UMASK;
        r_ua <= i_item.u_angle & UMASK;
    end

    // Normalize the radius word so that its leading one sits in the top bit.
    logic [31:0] norm_v;
    logic [4:0]  norm_lz;
    logic [31:0] r_norm_m;
    logic [5:0]  r_expn;
    logic [5:0]  expn_dly;

    always_comb begin
        norm_v  = r_ur;
        norm_lz = '0;
        if (norm_v[31:16] == 16'd0) begin
            norm_v     = norm_v << 16;
            norm_lz[4] = 1'b1;
        end
        if (norm_v[31:24] == 8'd0) begin
            norm_v     = norm_v << 8;
            norm_lz[3] = 1'b1;
        end
        if (norm_v[31:28] == 4'd0) begin
            norm_v     = norm_v << 4;
            norm_lz[2] = 1'b1;
        end
        if (norm_v[31:30] == 2'd0) begin
            norm_v     = norm_v << 2;
            norm_lz[1] = 1'b1;
        end
        if (norm_v[31] == 1'b0) begin
            norm_v     = norm_v << 1;
            norm_lz[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_norm_m <= norm_v;
        r_expn   <= {1'b0, norm_lz} + 6'd1;
    end

    gnbm_delay #(.W(6), .DEPTH(GNBM_LOG_CELLS)) u_expn_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_expn),
        .o_q     (expn_dly)
    );

    // Log chain
    logic [31:0] log_m    [GNBM_LOG_CELLS+1];
    logic [23:0] log_frac [GNBM_LOG_CELLS+1];

    assign log_m[0]    = r_norm_m;
    assign log_frac[0] = '0;

    for (genvar g = 0; g < GNBM_LOG_CELLS; g++) begin : g_log
        gnbm_log_cell u_cell (
            .i_clk  (i_clk),
            .i_m    (log_m[g]),
            .i_frac (log_frac[g]),
            .o_m    (log_m[g+1]),
            .o_frac (log_frac[g+1])
        );
    end

    // L = -2 ln u in Q6.24
    logic [29:0] neg_log2;
    logic [63:0] lq_full;
    logic [29:0] r_lq;

    assign neg_log2 = {expn_dly, 24'd0} - {6'd0, log_frac[GNBM_LOG_CELLS]};
    assign lq_full  = 64'(neg_log2) * 64'(GNBM_TWO_LN2_Q30);

    always_ff @(posedge i_clk) begin
        r_lq <= lq_full[59:30];
    end

    // Square root chain
    logic [41:0] sq_n   [GNBM_SQRT_CELLS+1];
    logic [41:0] sq_res [GNBM_SQRT_CELLS+1];
    logic [19:0] rho;

    assign sq_n[0]   = {4'd0, r_lq, 8'd0};
    assign sq_res[0] = '0;

    for (genvar g = 0; g < GNBM_SQRT_CELLS; g++) begin : g_sqrt
        gnbm_sqrt_cell #(.BIT_POS(GNBM_SQRT_TOP - 2 * g)) u_cell (
            .i_clk (i_clk),
            .i_n   (sq_n[g]),
            .i_res (sq_res[g]),
            .o_n   (sq_n[g+1]),
            .o_res (sq_res[g+1])
        );
    end

    assign rho = sq_res[GNBM_SQRT_CELLS][19:0];

    // Angle path, started late so that it lands beside rho.
    logic [31:0] ua_dly;
    logic [29:0] red;
    logic [63:0] y_full;
    logic [29:0] r_t1_y;
    logic [2:0]  r_t1_oct;
    logic [63:0] sq_full;
    logic [29:0] r_t2_y;
    logic [29:0] r_t2_sq;
    logic [2:0]  r_t2_oct;
    logic [2:0]  oct_dly;

    gnbm_delay #(.W(32), .DEPTH(36)) u_ua_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_ua),
        .o_q     (ua_dly)
    );

    // Odd octants measure the angle back from the octant's upper edge.
    assign red    = ua_dly[29] ? GNBM_OCT_SPAN - {1'b0, ua_dly[28:0]} : {1'b0, ua_dly[28:0]};
    assign y_full = 64'(red) * 64'(GNBM_HALF_PI_Q30);

    always_ff @(posedge i_clk) begin
        r_t1_y   <= y_full[59:30];
        r_t1_oct <= ua_dly[31:29];
    end

    assign sq_full = 64'(r_t1_y) * 64'(r_t1_y);

    always_ff @(posedge i_clk) begin
        r_t2_y   <= r_t1_y;
        r_t2_sq  <= sq_full[59:30];
        r_t2_oct <= r_t1_oct;
    end

    gnbm_delay #(.W(3), .DEPTH(2 * GNBM_HORNER_CELLS)) u_oct_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_t2_oct),
        .o_q     (oct_dly)
    );

    logic [29:0] hy  [GNBM_HORNER_CELLS+1];
    logic [29:0] hsq [GNBM_HORNER_CELLS+1];
    logic [30:0] hts [GNBM_HORNER_CELLS+1];
    logic [30:0] htc [GNBM_HORNER_CELLS+1];

    assign hy[0]  = r_t2_y;
    assign hsq[0] = r_t2_sq;
    assign hts[0] = GNBM_Q30_ONE;
    assign htc[0] = GNBM_Q30_ONE;

    for (genvar g = 0; g < GNBM_HORNER_CELLS; g++) begin : g_horner
        gnbm_horner_cell #(.DIV_S(GNBM_DIV_SIN[g]), .DIV_C(GNBM_DIV_COS[g])) u_cell (
            .i_clk (i_clk),
            .i_y   (hy[g]),
            .i_sq  (hsq[g]),
            .i_ts  (hts[g]),
            .i_tc  (htc[g]),
            .o_y   (hy[g+1]),
            .o_sq  (hsq[g+1]),
            .o_ts  (hts[g+1]),
            .o_tc  (htc[g+1])
        );
    end

    logic [63:0] sin_full;
    logic [63:0] cos_full;
    logic [30:0] r_sin;
    logic [30:0] r_cos;
    logic [2:0]  r_oct;

    assign sin_full = 64'(hy[GNBM_HORNER_CELLS]) * 64'(hts[GNBM_HORNER_CELLS]);
    assign cos_full = 64'(hsq[GNBM_HORNER_CELLS]) * 64'(htc[GNBM_HORNER_CELLS]);

    always_ff @(posedge i_clk) begin
        r_sin <= sin_full[60:30];
        r_cos <= GNBM_Q30_ONE - {1'b0, cos_full[60:31]};
        r_oct <= oct_dly;
    end

    // Octant mapping and scaling by rho
    logic        swap;
    logic [30:0] cmag;
    logic [30:0] smag;
    logic [63:0] pa_full;
    logic [63:0] pb_full;
    logic [35:0] r_pa;
    logic [35:0] r_pb;
    logic        r_nega;
    logic        r_negb;

    assign swap    = r_oct[1] ^ r_oct[0];
    assign cmag    = swap ? r_sin : r_cos;
    assign smag    = swap ? r_cos : r_sin;
    assign pa_full = 64'(rho) * 64'(cmag);
    assign pb_full = 64'(rho) * 64'(smag);

    always_ff @(posedge i_clk) begin
        r_pa   <= pa_full[49:14];
        r_pb   <= pb_full[49:14];
        r_nega <= r_oct[2] ^ r_oct[1];
        r_negb <= r_oct[2];
    end

    logic [63:0] ma_full;
    logic [63:0] mb_full;
    logic [27:0] r_maga;
    logic [27:0] r_magb;
    logic        r_nega2;
    logic        r_negb2;

    assign ma_full = 64'(r_pa) * 64'(r_noise_spread);
    assign mb_full = 64'(r_pb) * 64'(r_noise_spread);

    always_ff @(posedge i_clk) begin
        r_maga  <= ma_full[51:24];
        r_magb  <= mb_full[51:24];
        r_nega2 <= r_nega;
        r_negb2 <= r_negb;
    end

    // Output register
    logic         vld_dly;
    logic         r_strobe;
    t_gnbm_result r_result;

    gnbm_delay #(.W(1), .DEPTH(GNBM_LATENCY - 2)) u_vld_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_in_valid),
        .o_q     (vld_dly)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= vld_dly;
        end
        r_result.noise_a <= gnbm_sample(r_noise_mean, r_maga, r_nega2);
        r_result.noise_b <= gnbm_sample(r_noise_mean, r_magb, r_negb2);
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### hdl/gnbm_delay.sv
// Resettable shift line of DEPTH registers that delays a word.
module gnbm_delay
    import gnbm_pkg::*;
#(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_line[i] <= '0;
            end
        end else begin
            r_line[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

### hdl/gnbm_log_cell.sv
// One fraction bit of log2 by squaring the normalized mantissa.
module gnbm_log_cell
    import gnbm_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_m,
    input  logic [23:0] i_frac,
    output logic [31:0] o_m,
    output logic [23:0] o_frac
);

    logic [63:0] sq_full;
    logic [32:0] sq_q;
    logic [31:0] r_m;
    logic [23:0] r_frac;

    assign sq_full = 64'(i_m) * 64'(i_m);
    assign sq_q    = sq_full[63:31];

    // A square of two or more yields a one bit and is halved back into range.
    always_ff @(posedge i_clk) begin
        r_m    <= sq_q[32] ? sq_q[32:1] : sq_q[31:0];
        r_frac <= {i_frac[22:0], sq_q[32]};
    end

    assign o_m    = r_m;
    assign o_frac = r_frac;

endmodule

### hdl/gnbm_sqrt_cell.sv
// One restoring step of the integer square root.
module gnbm_sqrt_cell
    import gnbm_pkg::*;
#(
    parameter int BIT_POS = 0
) (
    input  logic        i_clk,
    input  logic [41:0] i_n,
    input  logic [41:0] i_res,
    output logic [41:0] o_n,
    output logic [41:0] o_res
);

    localparam logic [41:0] BIT_VAL = 42'd1 << BIT_POS;

    logic [41:0] trial;
    logic [41:0] n_n;
    logic [41:0] n_res;
    logic [41:0] r_n;
    logic [41:0] r_res;

    assign trial = i_res + BIT_VAL;

    always_comb begin
        if (i_n >= trial) begin
            n_n   = i_n - trial;
            n_res = (i_res >> 1) + BIT_VAL;
        end else begin
            n_n   = i_n;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_res <= n_res;
    end

    assign o_n   = r_n;
    assign o_res = r_res;

endmodule

### hdl/gnbm_horner_cell.sv
// One Horner step of the sine and cosine series, two stages deep.
module gnbm_horner_cell
    import gnbm_pkg::*;
#(
    parameter int DIV_S = 6,
    parameter int DIV_C = 12
) (
    input  logic        i_clk,
    input  logic [29:0] i_y,
    input  logic [29:0] i_sq,
    input  logic [30:0] i_ts,
    input  logic [30:0] i_tc,
    output logic [29:0] o_y,
    output logic [29:0] o_sq,
    output logic [30:0] o_ts,
    output logic [30:0] o_tc
);

    // Division by a constant as a multiply by a rounded-up reciprocal; exact
    // for every dividend below 2^30.
    localparam int SH_S = 30 + $clog2(DIV_S);
    localparam int SH_C = 30 + $clog2(DIV_C);
    localparam logic [31:0] RCP_S = 32'(((64'd1 << SH_S) + 64'(DIV_S) - 64'd1) / 64'(DIV_S));
    localparam logic [31:0] RCP_C = 32'(((64'd1 << SH_C) + 64'(DIV_C) - 64'd1) / 64'(DIV_C));

    logic [63:0] ps_full;
    logic [63:0] pc_full;
    logic [63:0] qs_full;
    logic [63:0] qc_full;
    logic [29:0] r_ps;
    logic [29:0] r_pc;
    logic [29:0] r_ya;
    logic [29:0] r_sqa;
    logic [30:0] r_ts;
    logic [30:0] r_tc;
    logic [29:0] r_yb;
    logic [29:0] r_sqb;

    assign ps_full = 64'(i_sq) * 64'(i_ts);
    assign pc_full = 64'(i_sq) * 64'(i_tc);

    always_ff @(posedge i_clk) begin
        r_ps  <= ps_full[59:30];
        r_pc  <= pc_full[59:30];
        r_ya  <= i_y;
        r_sqa <= i_sq;
    end

    assign qs_full = (64'(r_ps) * 64'(RCP_S)) >> SH_S;
    assign qc_full = (64'(r_pc) * 64'(RCP_C)) >> SH_C;

    always_ff @(posedge i_clk) begin
        r_ts  <= GNBM_Q30_ONE - qs_full[30:0];
        r_tc  <= GNBM_Q30_ONE - qc_full[30:0];
        r_yb  <= r_ya;
        r_sqb <= r_sqa;
    end

    assign o_y  = r_yb;
    assign o_sq = r_sqb;
    assign o_ts = r_ts;
    assign o_tc = r_tc;

endmodule

### hdl/gnbm_checker.sv
// Port-level checker of the Gaussian noise generator and its bind.
`include "gaussian_noise_box_muller_top_assert.svh"

module gnbm_checker
    import gnbm_pkg::*;
#(
    parameter int UNIFORM_BITS = GNBM_UNIFORM_BITS
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input t_gnbm_item i_item,
    input logic       o_strobe,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready
);

    localparam logic [31:0] UMASK = 32'hFFFF_FFFF << (32 - UNIFORM_BITS);
    localparam int LAT = GNBM_LATENCY;

    logic take_live;

    assign take_live = start && !busy && ((i_item.u_radius & UMASK) != 32'd0);

    // Every transfer with a usable radius comes out after the fixed latency.
    `GNBM_ASSERT_IMPL(a_latency, i_clk, i_rst_n, take_live, ##LAT o_strobe, "result missing")
    // Nothing comes out that was not a transfer with a usable radius.
    `GNBM_ASSERT_IMPL(a_no_spurious, i_clk, i_rst_n, !take_live, ##LAT !o_strobe, "stray result")
    `GNBM_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_strobe, "strobe after reset")
    `GNBM_ASSERT_IMPL(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready, "config stalled")

endmodule

bind gaussian_noise_box_muller_top gnbm_checker #(.UNIFORM_BITS(UNIFORM_BITS)) u_gnbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_item      (i_item),
    .o_strobe    (o_strobe),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

### tb/tb_gaussian_noise_box_muller_top.sv
// Self-checking testbench of the Box-Muller Gaussian noise generator.
module tb_gaussian_noise_box_muller_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gnbm_pkg::*;

    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] UMASK = 32'hFFFF_FFFF << (32 - GNBM_UNIFORM_BITS);

    // Bit-exact model of the noise arithmetic and the queue of expected samples.
    class noise_scoreboard;
        logic [15:0] mean_q88;
        logic [15:0] spread_q88;
        t_gnbm_result pending[$];
        int errors;
        int matched;

        function new();
            mean_q88 = GNBM_MEAN_RESET;
            spread_q88 = GNBM_SPREAD_RESET;
            errors = 0;
            matched = 0;
        endfunction

        function void set_reg(logic [GNBM_CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == GNBM_CFG_NOISE_MEAN) begin
                mean_q88 = data;
            end else if (idx == GNBM_CFG_NOISE_SPREAD) begin
                spread_q88 = data;
            end
        endfunction

        function longint unsigned neg_log2(longint unsigned r);
            int e;
            longint unsigned m;
            longint unsigned frac;
            e = 31;
            while (r[e] == 1'b0 && e > 0) e--;
            m = r << (31 - e);
            frac = 0;
            for (int i = 0; i < 24; i++) begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= (64'd1 << 32)) begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            return (longint'(32 - e) << 24) - frac;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 40;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function longint unsigned mulq(longint unsigned a, longint unsigned b);
            return (a * b) >> 30;
        endfunction

        function logic [31:0] scale_sample(longint unsigned rho, longint unsigned trig,
                                           bit neg);
            longint unsigned mag;
            longint sum;
            mag = (((rho * trig) >> 14) * spread_q88) >> 24;
            sum = longint'($signed(mean_q88)) * 256 + (neg ? -longint'(mag) : longint'(mag));
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            return sum[31:0];
        endfunction

        function void note_item(t_gnbm_item it);
            longint unsigned rho, f, red, y, sq, t, s, c, cm, sm;
            int oct;
            bit swap;
            logic [31:0] ur;
            logic [31:0] ua;
            t_gnbm_result res;
            ur = it.u_radius & UMASK;
            ua = it.u_angle & UMASK;
            if (ur == 0) return;
            rho = neg_log2(ur);
            rho = (rho * GNBM_TWO_LN2_Q30) >> 30;
            rho = int_sqrt(rho << 8);
            oct = ua[31:29];
            f = ua[28:0];
            red = oct[0] ? ((64'd1 << 29) - f) : f;
            y = (red * GNBM_HALF_PI_Q30) >> 30;
            sq = mulq(y, y);
            t = ONE_Q30 - sq / 72;
            t = ONE_Q30 - mulq(sq, t) / 42;
            t = ONE_Q30 - mulq(sq, t) / 20;
            t = ONE_Q30 - mulq(sq, t) / 6;
            s = mulq(y, t);
            t = ONE_Q30 - sq / 90;
            t = ONE_Q30 - mulq(sq, t) / 56;
            t = ONE_Q30 - mulq(sq, t) / 30;
            t = ONE_Q30 - mulq(sq, t) / 12;
            c = ONE_Q30 - mulq(sq, t) / 2;
            swap = ((oct + 1) & 2) != 0;
            cm = swap ? s : c;
            sm = swap ? c : s;
            res.noise_a = scale_sample(rho, cm, oct >= 2 && oct <= 5);
            res.noise_b = scale_sample(rho, sm, oct >= 4);
            pending.push_back(res);
        endfunction

        function void check_result(t_gnbm_result got);
            t_gnbm_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected sample a=%0d b=%0d", $time, got.noise_a,
                         got.noise_b);
                return;
            end
            want = pending.pop_front();
            if (got.noise_a !== want.noise_a) begin
                errors++;
                $display("%0t: noise_a expected %0d actual %0d", $time, want.noise_a,
                         got.noise_a);
            end
            if (got.noise_b !== want.noise_b) begin
                errors++;
                $display("%0t: noise_b expected %0d actual %0d", $time, want.noise_b,
                         got.noise_b);
            end
            matched++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_gnbm_item i_item;
    logic busy;
    logic o_strobe;
    t_gnbm_result o_result;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [GNBM_CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    noise_scoreboard sb;
    int idle_cycles;
    int items_sent;
    bit gaps_on;

    gaussian_noise_box_muller_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item), .busy(busy),
        .o_strobe(o_strobe), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Results and accepted items are sampled at the edge; the model sees them there.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_item(i_item);
            end
            if (o_strobe) begin
                sb.check_result(o_result);
            end
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("gaussian_noise_box_muller_top test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [GNBM_CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Holds start high until the transfer; a random gap may precede it.
    task automatic send_pair(logic [31:0] rad, logic [31:0] ang);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item.u_radius <= rad;
        i_item.u_angle <= ang;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (GNBM_LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_radius();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            1: return $urandom_range(1, 255);
            2: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [15:0] means [5];
        logic [15:0] spreads [5];
        means = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFF00, 16'h0180};
        spreads = '{16'h0100, 16'hFFFF, 16'h0000, 16'h0001, 16'h0340};
        sb = new();
        idle_cycles = 0;
        items_sent = 0;
        gaps_on = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = GNBM_CFG_NOISE_MEAN;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, radius extremes, zero radius, every octant edge.
        send_pair(32'h0000_0000, 32'h1234_5678);
        send_pair(32'h0000_0001, 32'h0000_0000);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'h2000_0000);
        send_pair(32'h0000_0000, 32'h0000_0000);
        for (int o = 0; o < 8; o++) begin
            send_pair(32'h0000_0003 + o, {o[2:0], 29'h0});
            send_pair(32'h4000_0000 + o, {o[2:0], 29'h1FFF_FFFF});
        end
        send_pair(32'hAAAA_AAAA, 32'h5555_5555);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA);
        drain();

        // Random phases, each under a different register setting.
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(GNBM_CFG_NOISE_MEAN, ph == 4 ? 16'($urandom) : means[ph]);
            write_reg(GNBM_CFG_NOISE_SPREAD, ph == 4 ? 16'($urandom) : spreads[ph]);
            gaps_on = (ph != 4);
            for (int k = 0; k < 130; k++) begin
                if ($urandom_range(0, 40) == 0) begin
                    send_pair(32'h0, $urandom);
                end else begin
                    send_pair(rand_radius(), $urandom);
                end
                if (gaps_on && $urandom_range(0, 30) == 0) gaps_on = 1'b0;
                else if (ph != 4 && !gaps_on && $urandom_range(0, 30) == 0) gaps_on = 1'b1;
            end
            drain();
        end
        // An out-of-range register index must be ignored.
        write_reg(8'hFF, 16'h1234);
        send_pair(32'h1234_5678, 32'h8765_4321);
        drain();

        $display("Sent %0d uniform pairs, %0d samples checked over 6 register settings.",
                 items_sent, sb.matched);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("gaussian_noise_box_muller_top test passed");
        end else begin
            $display("gaussian_noise_box_muller_top test failed");
        end
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/gnbm_pkg.sv
hdl/gnbm_delay.sv
hdl/gnbm_log_cell.sv
hdl/gnbm_sqrt_cell.sv
hdl/gnbm_horner_cell.sv
hdl/gaussian_noise_box_muller_top.sv
hdl/gnbm_checker.sv
tb/tb_gaussian_noise_box_muller_top.sv
